/* design/nep_pkg.sv */
package nep_pkg;

    // result kinds
    localparam logic [1:0] KIND_ENTRY     = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_TRUNCATED = 2'd2;
    localparam logic [1:0] KIND_NO_ROOM   = 2'd3;

    // bundle types and entry sizes
    localparam logic [7:0] TYPE_NULL    = 8'h00;
    localparam logic [7:0] TYPE_MOVABLE = 8'hFF;
    localparam logic [2:0] SIZE_FIXED   = 3'd3;
    localparam logic [2:0] SIZE_MOVABLE = 3'd6;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // parser phase
    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_TYPE  = 2'd1,
        PH_ENTRY = 2'd2
    } phase_t;

    // one queued word: a first result and whether a termination follows it
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ordinal;
        logic [7:0]  segment;
        logic [15:0] offset;
        logic        two;
    } q_word_t;

endpackage

/* design/nep_front.sv */
module nep_front
    import nep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic [7:0]  data_byte,
    input  logic [15:0] table_size,
    output logic        push,
    output q_word_t     push_word
);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] ord_reg, ord_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  seg_reg, seg_next;
    logic [7:0]  offlo_reg, offlo_next;
    logic        finished_reg, finished_next;

    logic        step;
    logic [15:0] pos_inc;
    logic        room_now;
    logic        room_after;
    logic [9:0]  rem3;
    logic [10:0] span;
    logic        trunc;
    logic [2:0]  idx_inc;
    logic        entry_done;
    logic        finish_first;
    logic        tail_term;
    logic        r_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_off;

    assign step     = in_fire && !finished_reg;
    assign pos_inc  = pos_reg + 16'd1;
    assign room_now = ({1'b0, pos_reg} + 17'd2) <= {1'b0, table_size};

    // span of the bundle being checked, count times 3 or 6
    assign rem3  = {2'b00, rem_reg} + {1'b0, rem_reg, 1'b0};
    assign span  = (data_byte == TYPE_MOVABLE) ? {rem3, 1'b0} : {1'b0, rem3};
    assign trunc = ({1'b0, pos_inc} + {6'd0, span}) > {1'b0, table_size};

    assign idx_inc    = idx_reg + 3'd1;
    assign entry_done = (type_reg == TYPE_MOVABLE) ? (idx_inc >= SIZE_MOVABLE)
                                                   : (idx_inc >= SIZE_FIXED);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    if (data_byte == TYPE_NULL)
                        phase_next = PH_COUNT;
                    else if (!trunc)
                        phase_next = PH_ENTRY;
                end
                PH_ENTRY:
                begin
                    if (entry_done && (rem_reg == 8'd1))
                        phase_next = PH_COUNT;
                end
                default:
                begin
                    if (room_now && (data_byte != 8'd0))
                        phase_next = PH_TYPE;
                    else
                        phase_next = PH_COUNT;
                end
            endcase
        end
    end

    // datapath and first result
    always_comb
    begin
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        type_next    = type_reg;
        ord_next     = ord_reg;
        idx_next     = idx_reg;
        seg_next     = seg_reg;
        offlo_next   = offlo_reg;
        finish_first = 1'b0;
        r_valid      = 1'b0;
        r_kind       = KIND_ENTRY;
        r_off        = 16'd0;
        if (step)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    pos_next  = pos_inc;
                    type_next = data_byte;
                    if (data_byte == TYPE_NULL)
                        ord_next = ord_reg + {8'd0, rem_reg};
                    else if (trunc)
                    begin
                        r_valid      = 1'b1;
                        r_kind       = KIND_TRUNCATED;
                        finish_first = 1'b1;
                    end
                    else
                        idx_next = 3'd0;
                end
                PH_ENTRY:
                begin
                    pos_next = pos_inc;
                    if (type_reg == TYPE_MOVABLE)
                    begin
                        if (idx_reg == 3'd3)
                            seg_next = (data_byte != 8'd0) ? data_byte - 8'd1 : 8'd0;
                        else if (idx_reg == 3'd4)
                            offlo_next = data_byte;
                    end
                    else
                    begin
                        seg_next = type_reg - 8'd1;
                        if (idx_reg == 3'd1)
                            offlo_next = data_byte;
                    end
                    if (entry_done)
                    begin
                        r_valid  = 1'b1;
                        r_kind   = KIND_ENTRY;
                        r_off    = {data_byte, offlo_next};
                        ord_next = ord_reg + 16'd1;
                        idx_next = 3'd0;
                        rem_next = rem_reg - 8'd1;
                    end
                    else
                        idx_next = idx_inc;
                end
                default:
                begin
                    if (!room_now)
                    begin
                        r_valid      = 1'b1;
                        r_kind       = KIND_NO_ROOM;
                        finish_first = 1'b1;
                    end
                    else if (data_byte == 8'd0)
                    begin
                        pos_next     = pos_inc;
                        r_valid      = 1'b1;
                        r_kind       = KIND_END;
                        finish_first = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        rem_next = data_byte;
                    end
                end
            endcase
        end
    end

    // termination when too few bytes remain for the next header
    assign room_after    = ({1'b0, pos_next} + 17'd2) <= {1'b0, table_size};
    assign tail_term     = step && !finish_first && (phase_next == PH_COUNT) && !room_after;
    assign finished_next = finished_reg || finish_first || tail_term;

    // word to the queue
    assign push = r_valid || tail_term;
    always_comb
    begin
        push_word = '0;
        if (r_valid)
        begin
            push_word.kind = r_kind;
            push_word.two  = tail_term;
            if (r_kind == KIND_ENTRY)
            begin
                push_word.ordinal = ord_reg;
                push_word.segment = seg_next;
                push_word.offset  = r_off;
            end
        end
        else
            push_word.kind = KIND_NO_ROOM;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COUNT;
            pos_reg      <= 16'd0;
            rem_reg      <= 8'd0;
            type_reg     <= 8'd0;
            ord_reg      <= 16'd1;
            idx_reg      <= 3'd0;
            seg_reg      <= 8'd0;
            offlo_reg    <= 8'd0;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            rem_reg      <= rem_next;
            type_reg     <= type_next;
            ord_reg      <= ord_next;
            idx_reg      <= idx_next;
            seg_reg      <= seg_next;
            offlo_reg    <= offlo_next;
            finished_reg <= finished_next;
        end
    end

endmodule

/* design/nep_queue.sv */
module nep_queue
    import nep_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_word_t push_word,
    input  logic    pop,
    output logic    full,
    output logic    q_valid,
    output q_word_t q_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_word_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_word  = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

endmodule

/* design/nep_back.sv */
module nep_back
    import nep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  q_word_t     q_word,
    output logic        pop,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [1:0]  kind,
    output logic [15:0] entry_ordinal,
    output logic [7:0]  segment_index,
    output logic [15:0] entry_offset,
    output logic        last
);

    logic        valid_reg, valid_next;
    logic        pend_reg, pend_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] ord_reg, ord_next;
    logic [7:0]  seg_reg, seg_next;
    logic [15:0] off_reg, off_next;
    logic        last_reg, last_next;
    logic        free;

    assign free = !valid_reg || !out_stall;

    // load the output register: pending termination first, then the queue
    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        kind_next  = kind_reg;
        ord_next   = ord_reg;
        seg_next   = seg_reg;
        off_next   = off_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (free)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                kind_next  = KIND_NO_ROOM;
                ord_next   = 16'd0;
                seg_next   = 8'd0;
                off_next   = 16'd0;
                last_next  = 1'b1;
            end
            else if (q_valid)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                pend_next  = q_word.two;
                kind_next  = q_word.kind;
                ord_next   = q_word.ordinal;
                seg_next   = q_word.segment;
                off_next   = q_word.offset;
                last_next  = !q_word.two;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        ord_reg  <= ord_next;
        seg_reg  <= seg_next;
        off_reg  <= off_next;
        last_reg <= last_next;
    end

    assign out_valid     = valid_reg;
    assign kind          = kind_reg;
    assign entry_ordinal = ord_reg;
    assign segment_index = seg_reg;
    assign entry_offset  = off_reg;
    assign last          = last_reg;

endmodule

/* design/ne_entry_table_parser_unit.sv */
// NE entry table parser: takes one table byte per cycle on the input channel and
// delivers export entries (ordinal, zero-based segment, offset) and one final
// termination word on the output channel. The front parser updates its
// position, bundle and ordinal counters in the cycle a byte is accepted, so the
// input sustains one byte per cycle; results leave through a queue of
// QUEUE_DEPTH words and an output register, one result per cycle while out_stall
// is low; an entry passes the queue and then the output register. Only the
// byte that ends the table can cause two results; the input stalls only while
// the queue is full. Write table_size while no table is in progress.
module ne_entry_table_parser_unit
    import nep_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] entry_ordinal,
    output logic [7:0]  segment_index,
    output logic [15:0] entry_offset,
    output logic        last
);

    logic [15:0] table_size_reg;
    logic        in_fire;
    logic        push;
    q_word_t     push_word;
    logic        full;
    logic        q_valid;
    q_word_t     q_word;
    logic        pop;

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_size_reg <= 16'd0;
        else if (cfg_we)
            table_size_reg <= cfg_data;
    end

    assign in_stall = full;
    assign in_fire  = in_valid && !in_stall;

    nep_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (data_byte),
        .table_size (table_size_reg),
        .push       (push),
        .push_word  (push_word)
    );

    nep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .full      (full),
        .q_valid   (q_valid),
        .q_word    (q_word)
    );

    nep_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_word        (q_word),
        .pop           (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .kind          (kind),
        .entry_ordinal (entry_ordinal),
        .segment_index (segment_index),
        .entry_offset  (entry_offset),
        .last          (last)
    );

endmodule

/* sim/ne_entry_table_parser_checker.sv */
module ne_entry_table_parser_checker
    import nep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] entry_ordinal,
    input  logic [7:0]  segment_index,
    input  logic [15:0] entry_offset,
    input  logic        last,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // byte slots inside an entry
    localparam logic [2:0] MOV_SEG_SLOT    = 3'd3;
    localparam logic [2:0] MOV_OFF_LO_SLOT = 3'd4;
    localparam logic [2:0] FIX_OFF_LO_SLOT = 3'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ordinal;
        logic [7:0]  segment;
        logic [15:0] offset;
        logic        last;
    } parse_word_t;

    parse_word_t awaited_words[$];
    parse_word_t step_words[2];
    int          step_count;
    int          errors;

    // own copy of the parser state
    logic [15:0] table_size;
    logic [15:0] byte_pos;
    phase_t      phase;
    logic [7:0]  remaining;
    logic [7:0]  bundle_type;
    logic [15:0] next_ord;
    logic [2:0]  byte_idx;
    logic [7:0]  held_seg;
    logic [7:0]  held_low;
    logic        done;

    function automatic logic [2:0] bytes_per_entry(input logic [7:0] t);
        return (t == TYPE_MOVABLE) ? SIZE_MOVABLE : SIZE_FIXED;
    endfunction

    function automatic logic header_fits(input logic [15:0] p, input logic [15:0] s);
        return ({1'b0, p} + 17'd2) <= {1'b0, s};
    endfunction

    task automatic add_word(input logic [1:0] k, input logic [15:0] o,
                            input logic [7:0] s, input logic [15:0] off);
        step_words[step_count] = '{kind: k, ordinal: o, segment: s, offset: off, last: 1'b0};
        step_count++;
    endtask

    // work out the words caused by one table byte
    task automatic parse_byte(input logic [7:0] b);
        logic [2:0] esz;
        logic [2:0] idx;
        step_count = 0;
        if (done)
            return;
        if (phase == PH_TYPE)
        begin
            byte_pos    = byte_pos + 16'd1;
            bundle_type = b;
            if (b == TYPE_NULL)
            begin
                next_ord = next_ord + 16'(remaining);
                phase    = PH_COUNT;
            end
            else if (32'(byte_pos) + 32'(remaining) * 32'(bytes_per_entry(b))
                     > 32'(table_size))
            begin
                add_word(KIND_TRUNCATED, 16'd0, 8'd0, 16'd0);
                done = 1'b1;
            end
            else
            begin
                phase    = PH_ENTRY;
                byte_idx = 3'd0;
            end
        end
        else if (phase == PH_ENTRY)
        begin
            esz      = bytes_per_entry(bundle_type);
            idx      = byte_idx;
            byte_pos = byte_pos + 16'd1;
            if (esz == SIZE_MOVABLE)
            begin
                if (idx == MOV_SEG_SLOT)
                    held_seg = (b != 8'd0) ? b - 8'd1 : 8'd0;
                else if (idx == MOV_OFF_LO_SLOT)
                    held_low = b;
            end
            else
            begin
                held_seg = bundle_type - 8'd1;
                if (idx == FIX_OFF_LO_SLOT)
                    held_low = b;
            end
            idx = idx + 3'd1;
            if (idx >= esz)
            begin
                add_word(KIND_ENTRY, next_ord, held_seg, {b, held_low});
                next_ord  = next_ord + 16'd1;
                byte_idx  = 3'd0;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0)
                    phase = PH_COUNT;
            end
            else
                byte_idx = idx;
        end
        else
        begin
            phase = PH_COUNT;
            if (!header_fits(byte_pos, table_size))
            begin
                add_word(KIND_NO_ROOM, 16'd0, 8'd0, 16'd0);
                done = 1'b1;
            end
            else if (b == 8'd0)
            begin
                byte_pos = byte_pos + 16'd1;
                add_word(KIND_END, 16'd0, 8'd0, 16'd0);
                done = 1'b1;
            end
            else
            begin
                byte_pos  = byte_pos + 16'd1;
                remaining = b;
                phase     = PH_TYPE;
            end
        end
        // not enough bytes left for another header
        if (!done && phase == PH_COUNT && !header_fits(byte_pos, table_size))
        begin
            add_word(KIND_NO_ROOM, 16'd0, 8'd0, 16'd0);
            done = 1'b1;
        end
        if (step_count > 0)
            step_words[step_count - 1].last = 1'b1;
        for (int i = 0; i < step_count; i++)
            awaited_words.push_back(step_words[i]);
    endtask

    task automatic compare_field(input string name, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // compare one delivered word with the oldest awaited one
    task automatic check_word();
        parse_word_t want;
        if (awaited_words.size() == 0)
        begin
            $display({"%0t: unexpected word, expected none, ",
                      "actual kind %0d ord %0h seg %0h off %0h last %0b"},
                     $time, kind, entry_ordinal, segment_index, entry_offset, last);
            errors++;
            return;
        end
        want = awaited_words.pop_front();
        compare_field("kind", 16'(want.kind), 16'(kind));
        compare_field("entry_ordinal", want.ordinal, entry_ordinal);
        compare_field("segment_index", 16'(want.segment), 16'(segment_index));
        compare_field("entry_offset", want.offset, entry_offset);
        compare_field("last", 16'(want.last), 16'(last));
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size  = 16'd0;
            byte_pos    = 16'd0;
            phase       = PH_COUNT;
            remaining   = 8'd0;
            bundle_type = 8'd0;
            next_ord    = 16'd1;
            byte_idx    = 3'd0;
            held_seg    = 8'd0;
            held_low    = 8'd0;
            done        = 1'b0;
            errors      = 0;
            awaited_words.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
                table_size = cfg_data;
            if (in_valid && !in_stall)
                parse_byte(data_byte);
            if (out_valid && !out_stall)
                check_word();
            fail_count <= errors;
            pending    <= awaited_words.size();
        end
    end

endmodule

/* sim/tb_ne_entry_table_parser_unit.sv */
module tb_ne_entry_table_parser_unit
    import nep_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF       = 10;
    localparam int          RESET_CYCLES   = 4;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          RANDOM_BYTES   = 480;
    localparam int          PHASES         = 6;
    localparam int          TAIL_BYTES     = 20;
    localparam logic [15:0] MAX_SIZE       = 16'hFFFF;

    // ways of ending the one table of the run
    typedef enum int {
        END_ZERO_COUNT,
        END_TRUNCATED,
        END_NO_ROOM,
        END_BUNDLE_FILLS,
        END_SHRUNK_MID
    } table_end_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_data  = 16'd0;
    logic        in_valid  = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  kind;
    logic [15:0] entry_ordinal;
    logic [7:0]  segment_index;
    logic [15:0] entry_offset;
    logic        last;
    int          fail_count;
    int          pending;

    int table_pos  = 0;
    int idle_count = 0;
    bit hold_req   = 1'b0;
    bit tx_quiet   = 1'b1;
    bit rx_quiet   = 1'b0;

    always #CLK_HALF clk = ~clk;

    ne_entry_table_parser_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .entry_ordinal (entry_ordinal),
        .segment_index (segment_index),
        .entry_offset  (entry_offset),
        .last          (last)
    );

    ne_entry_table_parser_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .entry_ordinal (entry_ordinal),
        .segment_index (segment_index),
        .entry_offset  (entry_offset),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int bytes_per_entry(input logic [7:0] t);
        return (t == TYPE_MOVABLE) ? int'(SIZE_MOVABLE) : int'(SIZE_FIXED);
    endfunction

    // entry contents lean towards the extremes
    function automatic logic [7:0] entry_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // offer one byte and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        data_byte <= b;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        table_pos++;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_entries(input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(entry_byte());
    endtask

    task automatic send_bundle(input logic [7:0] count, input logic [7:0] btype);
        send_byte(count);
        send_byte(btype);
        if (btype != TYPE_NULL)
            send_entries(int'(count) * bytes_per_entry(btype));
    endtask

    // pause the sender until every awaited word has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [15:0] v);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_bundle();
        int         r;
        logic [7:0] count;
        logic [7:0] btype;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            btype = TYPE_NULL;
            count = 8'($urandom_range(1, 255));
        end
        else
        begin
            if (r >= 55)
                btype = TYPE_MOVABLE;
            else if ($urandom_range(0, 9) == 0)
                btype = $urandom_range(0, 1) ? 8'd1 : 8'd254;
            else
                btype = 8'($urandom_range(1, 254));
            if ($urandom_range(0, 4) == 0)
                count = 8'($urandom_range(5, 16));
            else
                count = 8'($urandom_range(1, 4));
        end
        send_bundle(count, btype);
    endtask

    // receiver side: random stalls, one long hold-off on request
    initial
    begin
        int len;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_stall <= !rx_quiet && ($urandom_range(0, 2) == 0);
                len = pick_gap() + 1;
                repeat (len) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_count <= 0;
            else if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_count <= idle_count + 1;
        end
    end

    // stimulus
    initial
    begin
        logic [7:0] directed_bytes [26];
        table_end_t how_end;
        int         start_pos;
        int         count_v;
        int         cut;
        logic [7:0] btype;
        directed_bytes = '{
            8'h01, 8'h01, 8'h00, 8'h00, 8'h00,
            8'h01, 8'hFE, 8'h5A, 8'hFF, 8'hFF,
            8'hFF, 8'h00,
            8'h02, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h34, 8'h12,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_size(MAX_SIZE);

        // directed: segment and offset extremes, a full null bundle
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        drain();

        // random bundles in phases, new table size between phases
        for (int ph = 0; ph < PHASES; ph++)
        begin
            tx_quiet = (ph == 1) || ($urandom_range(0, 3) == 0);
            rx_quiet = (ph != 1) && ($urandom_range(0, 3) == 0);
            if (ph == 1)
                hold_req = 1'b1;
            start_pos = table_pos;
            while (table_pos - start_pos < RANDOM_BYTES / PHASES)
                random_bundle();
            drain();
            if (ph == 2)
            begin
                write_size(16'd0);
                write_size(MAX_SIZE);
            end
            else
                write_size(16'($urandom_range(table_pos + 1500, 65535)));
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // end of table
        how_end = table_end_t'($urandom_range(0, 4));
        case (how_end)
            END_ZERO_COUNT:
                send_byte(8'h00);
            END_TRUNCATED:
            begin
                drain();
                write_size(16'(table_pos + $urandom_range(2, 20)));
                send_byte(8'($urandom_range(8, 255)));
                send_byte($urandom_range(0, 1) ? TYPE_MOVABLE : 8'($urandom_range(1, 254)));
            end
            END_NO_ROOM:
            begin
                drain();
                if ($urandom_range(0, 1))
                    write_size(16'd0);
                else
                    write_size(16'(table_pos + $urandom_range(0, 1)));
                send_byte(8'($urandom));
            end
            END_BUNDLE_FILLS:
            begin
                drain();
                count_v = $urandom_range(1, 4);
                case ($urandom_range(0, 2))
                    0:       btype = TYPE_NULL;
                    1:       btype = 8'($urandom_range(1, 254));
                    default: btype = TYPE_MOVABLE;
                endcase
                write_size(16'(table_pos + 2 + $urandom_range(0, 1)
                               + ((btype == TYPE_NULL) ? 0 : count_v * bytes_per_entry(btype))));
                send_bundle(8'(count_v), btype);
            end
            default:
            begin
                // size dropped to zero inside a bundle that already passed its check
                drain();
                count_v = $urandom_range(2, 5);
                btype   = $urandom_range(0, 1) ? TYPE_MOVABLE : 8'($urandom_range(1, 254));
                send_byte(8'(count_v));
                send_byte(btype);
                cut = $urandom_range(1, count_v * bytes_per_entry(btype) - 1);
                send_entries(cut);
                drain();
                write_size(16'd0);
                send_entries(count_v * bytes_per_entry(btype) - cut);
            end
        endcase

        // bytes after the end are ignored
        repeat (TAIL_BYTES) send_byte(8'($urandom));
        drain();

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
